// ----- hdl/esss_pkg.sv -----
`timescale 1ns / 1ps

package esss_pkg;

    localparam int BALL_RADIUS_DEF = 32;

    localparam int COORD_W = 12;   // signed screen coordinates
    localparam int REG_W   = 11;   // config registers, tile width, span ends
    localparam int WORK_W  = 14;   // signed working coordinates
    localparam int RX_W    = 8;    // horizontal radius, up to 255
    localparam int RY_W    = 6;    // vertical radius, up to 63
    localparam int NUM_W   = 19;   // h * radius
    localparam int DEN_W   = 13;   // 3 * jump_height + 1
    localparam int SQ_W    = 2 * RY_W;
    localparam int PROD_W  = RX_W + RY_W;
    localparam int RX_MIN  = 8;
    localparam int RY_MIN  = 3;
    localparam int CTR_OFS = 6;
    localparam int GROUND_RESET = 200;
    localparam int JUMP_RESET   = 100;

    typedef enum logic [0:0] {
        CFG_GROUND_ROW  = 1'b0,
        CFG_JUMP_HEIGHT = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [4:0]                pad;
        logic signed [COORD_W-1:0] clip_right;
        logic signed [COORD_W-1:0] clip_left;
        logic [REG_W-1:0]          tile_width;
        logic signed [COORD_W-1:0] tile_left;
        logic signed [COORD_W-1:0] scan_row;
        logic signed [COORD_W-1:0] ball_y;
        logic signed [COORD_W-1:0] ball_x;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]       pad;
        logic [REG_W-1:0] span_end;
        logic [REG_W-1:0] span_start;
    } out_beat_t;

    // item fields that ride along with every stage up to the clip range stage
    typedef struct packed {
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] tl;
        logic [REG_W-1:0]          tw;
        logic signed [COORD_W-1:0] cl;
        logic signed [COORD_W-1:0] cr;
    } geom_t;

    typedef struct packed {
        geom_t                    g;
        logic signed [WORK_W-1:0] dy;
    } pay_rad_t;

    typedef struct packed {
        geom_t            g;
        logic [RX_W-1:0]  rx;
        logic [RY_W-1:0]  ry;
        logic             in_ell;
    } pay_sq_t;

    typedef struct packed {
        geom_t g;
        logic  in_ell;
    } pay_dx_t;

endpackage

// ----- hdl/esss_div.sv -----
`timescale 1ns / 1ps

module esss_div #(
    parameter int NW = 19,
    parameter int DW = 13,
    parameter int QW = 4,
    parameter int PW = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [PW-1:0] out_pay
);

    localparam int WW = NW + DW + QW;

    logic [QW-1:0] v_reg;
    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    // one quotient bit per stage, most significant first
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic          v_in;
        logic [NW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [PW-1:0] pay_in;
        logic [WW-1:0] rem_w;
        logic [WW-1:0] dsh;
        logic          ge;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = in_num;
            assign den_in = in_den;
            assign quo_in = '0;
            assign pay_in = in_pay;
        end else begin : g_rest
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign pay_in = pay_reg[k-1];
        end

        always_comb
        begin
            rem_w    = WW'(rem_in);
            dsh      = WW'(den_in) << (QW - 1 - k);
            ge       = (rem_w >= dsh);
            rem_next = ge ? NW'(rem_w - dsh) : rem_in;
            quo_next = quo_in;
            quo_next[QW-1-k] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_in;
                quo_reg[k] <= quo_next;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

// ----- hdl/esss_isqrt.sv -----
`timescale 1ns / 1ps

module esss_isqrt #(
    parameter int RW = 6,
    parameter int PW = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_valid,
    input  logic [2*RW-1:0] in_x,
    input  logic [PW-1:0]   in_pay,
    output logic            out_valid,
    output logic [RW-1:0]   out_root,
    output logic [PW-1:0]   out_pay
);

    logic [RW-1:0]   v_reg;
    logic [2*RW-1:0] x_reg    [RW];
    logic [RW-1:0]   root_reg [RW];
    logic [PW-1:0]   pay_reg  [RW];

    // set one root bit per stage if its square still fits
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            v_in;
        logic [2*RW-1:0] x_in;
        logic [RW-1:0]   root_in;
        logic [PW-1:0]   pay_in;
        logic [RW-1:0]   trial;
        logic [2*RW-1:0] trial_sq;
        logic [RW-1:0]   root_next;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign x_in    = in_x;
            assign root_in = '0;
            assign pay_in  = in_pay;
        end else begin : g_rest
            assign v_in    = v_reg[k-1];
            assign x_in    = x_reg[k-1];
            assign root_in = root_reg[k-1];
            assign pay_in  = pay_reg[k-1];
        end

        always_comb
        begin
            trial     = root_in | (RW'(1) << (RW - 1 - k));
            trial_sq  = (2*RW)'(trial) * (2*RW)'(trial);
            root_next = (trial_sq <= x_in) ? trial : root_in;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k]    <= x_in;
                root_reg[k] <= root_next;
                pay_reg[k]  <= pay_in;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_pay   = pay_reg[RW-1];

endmodule

// ----- hdl/ellipse_shadow_scanline_span_core.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Beat contents
// s_*       in         ball_x, ball_y, scan_row, tile_left, tile_width, clip_left, clip_right
// m_*       out        tdata: span_start, span_end; tuser: span_valid
// cfg_*     in         cfg_index selects ground_row or jump_height, cfg_data is the value
//
// One beat per cycle in, one span per cycle out unless the output stalls. The two parallel
// radius dividers, the 6-step square root and the 8-step half-width divider are unrolled
// into register stages. Reset clears the stage valid bits and loads the config defaults.
// m_tready low while a span is held freezes every stage and drops s_tready.

module ellipse_shadow_scanline_span_core
    import esss_pkg::*;
#(
    parameter int BALL_RADIUS = BALL_RADIUS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [87:0]  s_tdata,   // ball_x, ball_y, scan_row, tile_left, tile_width,
                                    // clip_left, clip_right, zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [23:0]  m_tdata,   // span_start, span_end, zero pad
    output logic         m_tuser,   // span_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [0:0]   cfg_index,
    input  logic [REG_W-1:0] cfg_data
);

    localparam int RY0 = BALL_RADIUS / 4;
    localparam int QW  = $clog2(BALL_RADIUS / 3 + 1);

    logic adv;

    // ---------------- configuration ----------------
    logic [REG_W-1:0] ground_reg;
    logic [REG_W-1:0] jump_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ground_reg <= REG_W'(GROUND_RESET);
            jump_reg   <= REG_W'(JUMP_RESET);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GROUND_ROW:  ground_reg <= cfg_data;
                CFG_JUMP_HEIGHT: jump_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage A: height, divider operands ----------------
    in_beat_t                 in_beat;
    logic signed [WORK_W-1:0] h_raw;
    logic [REG_W-1:0]         h_cl;
    logic signed [WORK_W-1:0] dy_next;
    pay_rad_t                 pay_a_next;

    logic             a_v_reg;
    logic [NUM_W-1:0] num_rx_reg;
    logic [NUM_W-1:0] num_ry_reg;
    logic [DEN_W-1:0] den_rx_reg;
    logic [DEN_W-1:0] den_ry_reg;
    pay_rad_t         pay_a_reg;

    assign in_beat  = in_beat_t'(s_tdata);
    assign s_tready = adv;

    always_comb
    begin
        h_raw = $signed({3'b000, ground_reg}) - WORK_W'(in_beat.ball_y)
                - WORK_W'(BALL_RADIUS);
        if (h_raw < 0)
            h_cl = '0;
        else if (h_raw > $signed({3'b000, jump_reg}))
            h_cl = jump_reg;
        else
            h_cl = h_raw[REG_W-1:0];
        dy_next = WORK_W'(in_beat.scan_row) - $signed({3'b000, ground_reg})
                  - WORK_W'(CTR_OFS);
        pay_a_next.g.bx = in_beat.ball_x;
        pay_a_next.g.tl = in_beat.tile_left;
        pay_a_next.g.tw = in_beat.tile_width;
        pay_a_next.g.cl = in_beat.clip_left;
        pay_a_next.g.cr = in_beat.clip_right;
        pay_a_next.dy   = dy_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_v_reg <= 1'b0;
        else if (adv)
            a_v_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_rx_reg <= NUM_W'(h_cl) * NUM_W'(BALL_RADIUS);
            num_ry_reg <= NUM_W'(h_cl) * NUM_W'(RY0);
            den_rx_reg <= DEN_W'(3 * jump_reg + 1);
            den_ry_reg <= DEN_W'(2 * jump_reg + 1);
            pay_a_reg  <= pay_a_next;
        end
    end

    // ---------------- radius dividers ----------------
    logic          rd_v;
    logic [QW-1:0] q_rx;
    logic [QW-1:0] q_ry;
    pay_rad_t      pay_r;
    logic          unused_v;
    logic [$bits(pay_rad_t)-1:0] unused_pay;

    esss_div #(.NW(NUM_W), .DW(DEN_W), .QW(QW), .PW($bits(pay_rad_t))) u_div_rx (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(a_v_reg), .in_num(num_rx_reg), .in_den(den_rx_reg), .in_pay(pay_a_reg),
        .out_valid(rd_v), .out_quo(q_rx), .out_pay(pay_r)
    );

    esss_div #(.NW(NUM_W), .DW(DEN_W), .QW(QW), .PW($bits(pay_rad_t))) u_div_ry (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(a_v_reg), .in_num(num_ry_reg), .in_den(den_ry_reg), .in_pay(pay_a_reg),
        .out_valid(unused_v), .out_quo(q_ry), .out_pay(unused_pay)
    );

    // ---------------- stage B: radii, row test, radicand ----------------
    logic [RX_W:0]         rx_full;
    logic [RX_W-1:0]       rx_c;
    logic [RX_W:0]         ry_full;
    logic [RY_W-1:0]       ry_c;
    logic [WORK_W-1:0]     dy_mag;
    logic                  in_ell;
    logic [SQ_W-1:0]       sq_next;
    pay_sq_t               pay_b_next;

    logic            b_v_reg;
    logic [SQ_W-1:0] sq_reg;
    pay_sq_t         pay_b_reg;

    always_comb
    begin
        rx_full = (RX_W+1)'(BALL_RADIUS) - (RX_W+1)'(q_rx);
        rx_c    = (rx_full < (RX_W+1)'(RX_MIN)) ? RX_W'(RX_MIN) : rx_full[RX_W-1:0];
        ry_full = (RX_W+1)'(RY0) - (RX_W+1)'(q_ry);
        ry_c    = (ry_full < (RX_W+1)'(RY_MIN)) ? RY_W'(RY_MIN) : ry_full[RY_W-1:0];
        dy_mag  = pay_r.dy[WORK_W-1] ? WORK_W'(-pay_r.dy) : WORK_W'(pay_r.dy);
        in_ell  = (dy_mag <= WORK_W'(ry_c));
        if (in_ell)
            sq_next = SQ_W'(ry_c) * SQ_W'(ry_c)
                      - SQ_W'(dy_mag[RY_W-1:0]) * SQ_W'(dy_mag[RY_W-1:0]);
        else
            sq_next = '0;
        pay_b_next.g      = pay_r.g;
        pay_b_next.rx     = rx_c;
        pay_b_next.ry     = ry_c;
        pay_b_next.in_ell = in_ell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_v_reg <= 1'b0;
        else if (adv)
            b_v_reg <= rd_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_reg    <= sq_next;
            pay_b_reg <= pay_b_next;
        end
    end

    // ---------------- square root ----------------
    logic            sr_v;
    logic [RY_W-1:0] root;
    pay_sq_t         pay_s;

    esss_isqrt #(.RW(RY_W), .PW($bits(pay_sq_t))) u_isqrt (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(b_v_reg), .in_x(sq_reg), .in_pay(pay_b_reg),
        .out_valid(sr_v), .out_root(root), .out_pay(pay_s)
    );

    // ---------------- stage C: rx * root ----------------
    pay_dx_t           pay_c_next;
    logic              c_v_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [RY_W-1:0]   ry_c_reg;
    pay_dx_t           pay_c_reg;

    always_comb
    begin
        pay_c_next.g      = pay_s.g;
        pay_c_next.in_ell = pay_s.in_ell;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_v_reg <= 1'b0;
        else if (adv)
            c_v_reg <= sr_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg  <= PROD_W'(pay_s.rx) * PROD_W'(root);
            ry_c_reg  <= pay_s.ry;
            pay_c_reg <= pay_c_next;
        end
    end

    // ---------------- half-width divider ----------------
    logic            hw_v;
    logic [RX_W-1:0] dx;
    pay_dx_t         pay_h;

    esss_div #(.NW(PROD_W), .DW(RY_W), .QW(RX_W), .PW($bits(pay_dx_t))) u_div_dx (
        .clk(clk), .rst_n(rst_n), .adv(adv),
        .in_valid(c_v_reg), .in_num(prod_reg), .in_den(ry_c_reg), .in_pay(pay_c_reg),
        .out_valid(hw_v), .out_quo(dx), .out_pay(pay_h)
    );

    // ---------------- stage D: clip range ----------------
    logic signed [WORK_W-1:0] x0_a;
    logic signed [WORK_W-1:0] x1_a;
    logic signed [WORK_W-1:0] cr1;
    logic signed [WORK_W-1:0] x0_next;
    logic signed [WORK_W-1:0] x1_next;

    logic                     d_v_reg;
    logic                     d_ok_reg;
    logic signed [WORK_W-1:0] x0_reg;
    logic signed [WORK_W-1:0] x1_reg;
    logic signed [COORD_W-1:0] tl_reg;
    logic [REG_W-1:0]         tw_reg;

    always_comb
    begin
        x0_a    = WORK_W'(pay_h.g.bx) - $signed(WORK_W'(dx));
        x1_a    = WORK_W'(pay_h.g.bx) + $signed(WORK_W'(dx)) + WORK_W'(1);
        cr1     = WORK_W'(pay_h.g.cr) + WORK_W'(1);
        x0_next = (x0_a < WORK_W'(pay_h.g.cl)) ? WORK_W'(pay_h.g.cl) : x0_a;
        x1_next = (x1_a > cr1) ? cr1 : x1_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_v_reg <= 1'b0;
        else if (adv)
            d_v_reg <= hw_v;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_ok_reg <= pay_h.in_ell && (x1_next > x0_next);
            x0_reg   <= x0_next;
            x1_reg   <= x1_next;
            tl_reg   <= pay_h.g.tl;
            tw_reg   <= pay_h.g.tw;
        end
    end

    // ---------------- stage E: tile clip, output register ----------------
    logic signed [WORK_W-1:0] te;
    logic signed [WORK_W-1:0] x0_t;
    logic signed [WORK_W-1:0] x1_t;
    logic signed [WORK_W-1:0] rel0;
    logic signed [WORK_W-1:0] rel1;
    logic                     ok_t;

    logic             out_v_reg;
    logic             span_valid_reg;
    logic [REG_W-1:0] span_start_reg;
    logic [REG_W-1:0] span_end_reg;
    out_beat_t        out_beat;

    always_comb
    begin
        te   = WORK_W'(tl_reg) + $signed(WORK_W'(tw_reg));
        x0_t = (x0_reg < WORK_W'(tl_reg)) ? WORK_W'(tl_reg) : x0_reg;
        x1_t = (x1_reg > te) ? te : x1_reg;
        ok_t = d_ok_reg && (x1_t > x0_t);
        rel0 = x0_t - WORK_W'(tl_reg);
        rel1 = x1_t - WORK_W'(tl_reg);
    end

    assign adv = !out_v_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= d_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            span_valid_reg <= ok_t;
            span_start_reg <= ok_t ? rel0[REG_W-1:0] : '0;
            span_end_reg   <= ok_t ? rel1[REG_W-1:0] : '0;
        end
    end

    always_comb
    begin
        out_beat.pad        = '0;
        out_beat.span_start = span_start_reg;
        out_beat.span_end   = span_end_reg;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_beat;
    assign m_tuser  = span_valid_reg;

endmodule
